/* hw/rtl/rmsg_pkg.sv */
package rmsg_pkg;

  // Default field widths.
  localparam int MOMENTUM_BITS_DEF = 16;
  localparam int RESULT_BITS_DEF   = 18;

  // Width of one digit of the multiplier operand handled per pipeline stage.
  localparam int MUL_DIGIT = 16;

  // Result status codes.
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_PT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NEG_RAD   = 2'd2;
  localparam logic [STAT_W-1:0] ST_GAMMA_SAT = 2'd3;

endpackage

/* hw/rtl/rmsg_mulp.sv */
module rmsg_mulp #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int TW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [TW-1:0]    tag_i,
  output logic             out_vld,
  output logic [AW+BW-1:0] p_o,
  output logic [TW-1:0]    tag_o
);
  import rmsg_pkg::*;

  // One digit of b is multiplied into the running sum per stage.
  localparam int NC  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BXW = NC * MUL_DIGIT;
  localparam int PW  = AW + BW;

  logic            vld_r [NC];
  logic [AW-1:0]   a_r   [NC];
  logic [BXW-1:0]  b_r   [NC];
  logic [PW-1:0]   acc_r [NC];
  logic [TW-1:0]   tag_r [NC];

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic                  vld_in;
    logic [AW-1:0]         a_in;
    logic [BXW-1:0]        b_in;
    logic [PW-1:0]         acc_in;
    logic [TW-1:0]         tag_in;
    logic [AW+MUL_DIGIT-1:0] pp;
    logic [PW-1:0]         acc_nxt;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign a_in   = a_i;
      assign b_in   = BXW'(b_i);
      assign acc_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_comb begin
      pp      = a_in * b_in[k*MUL_DIGIT +: MUL_DIGIT];
      acc_nxt = acc_in + (PW'(pp) << (k * MUL_DIGIT));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]   <= a_in;
        b_r[k]   <= b_in;
        acc_r[k] <= acc_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_vld = vld_r[NC-1];
  assign p_o     = acc_r[NC-1];
  assign tag_o   = tag_r[NC-1];

endmodule

/* hw/rtl/rmsg_root.sv */
module rmsg_root #(
  parameter int RW = 34,
  parameter int TW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [RW-1:0]         rad_i,
  input  logic [TW-1:0]         tag_i,
  output logic                  out_vld,
  output logic [(RW+1)/2-1:0]   root_o,
  output logic [(RW+1)/2:0]     rem_o,
  output logic [TW-1:0]         tag_o
);

  // One root bit per stage; x holds the remaining radicand, y the partial root.
  localparam int QW = (RW + 1) / 2;
  localparam int XW = 2 * QW;

  logic          vld_r [QW];
  logic [XW-1:0] x_r   [QW];
  logic [XW-1:0] y_r   [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [XW-1:0] x_in;
    logic [XW-1:0] y_in;
    logic [TW-1:0] tag_in;
    logic [XW-1:0] bitv;
    logic [XW-1:0] trial;
    logic [XW-1:0] x_nxt;
    logic [XW-1:0] y_nxt;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign x_in   = XW'(rad_i);
      assign y_in   = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign x_in   = x_r[k-1];
      assign y_in   = y_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_comb begin
      bitv  = XW'(1) << (2 * (QW - 1 - k));
      trial = y_in + bitv;
      if (x_in >= trial) begin
        x_nxt = x_in - trial;
        y_nxt = (y_in >> 1) + bitv;
      end else begin
        x_nxt = x_in;
        y_nxt = y_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        tag_r[k] <= tag_in;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign root_o  = y_r[QW-1][QW-1:0];
  assign rem_o   = x_r[QW-1][QW:0];
  assign tag_o   = tag_r[QW-1];

endmodule

/* hw/rtl/razor_mr_star_gamma_core.sv */
// Razor MR* and gamma*MR* for one jet pair per word, fully pipelined.
// Throughput: one word per cycle; a stall at the output freezes the whole pipeline.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other state.
module razor_mr_star_gamma_core #(
  parameter int MOMENTUM_BITS = rmsg_pkg::MOMENTUM_BITS_DEF,
  parameter int RESULT_BITS   = rmsg_pkg::RESULT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // Fields from bit 0 up: jet_a_px, jet_a_py, jet_a_pz, jet_b_px, jet_b_py, jet_b_pz.
  input  logic [((6*MOMENTUM_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0 up: mr_star, gamma_mr_star.
  output logic [((2*RESULT_BITS+7)/8)*8-1:0]   out_tdata,
  // Field: status.
  output logic [rmsg_pkg::STAT_W-1:0]          out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);
  import rmsg_pkg::*;

  // With P = |p|^2 per jet, S = |aT+bT|^2, D = |bT|^2-|aT|^2 and base = Pa+Pb-(az+bz)^2:
  //   T = base + 2*sqrt(Pa*Pb)          (gamma*MR* = sqrt(T))
  //   X = T - D^2/S                     (MR* = sqrt(X))
  // Both roots only need the integer floors of T and X.  With g = floor(sqrt(4q)),
  // e = 4q - g^2, Qc = floor(D^2/S) and rc its remainder, floor(X) is
  // base + g - Qc, less one when the fraction of sqrt(4q) is below rc/S.  That test
  // is done exactly: S*(S*e - 2*g*rc) >= rc^2, and equality means X is an integer.
  localparam int MB   = MOMENTUM_BITS;
  localparam int RB   = RESULT_BITS;
  localparam int OW   = ((2*RB+7)/8)*8;
  localparam int SQW  = 2*MB - 1;     // square of one component
  localparam int SSW  = 2*MB + 1;     // square of a sum of two components
  localparam int PW2  = 2*MB;         // |p|^2 of one jet, transverse difference
  localparam int SW   = 2*MB + 2;     // S
  localparam int BSW  = 2*MB + 2;     // base, signed
  localparam int QW4  = 4*MB;         // Pa*Pb and D^2
  localparam int GW   = 2*MB + 1;     // g
  localparam int EW   = 2*MB + 2;     // e
  localparam int QCW  = 2*MB + 1;     // Qc
  localparam int RCW  = SW;           // rc
  localparam int DW   = 4*MB + 2;     // divider remainder and trial
  localparam int SEW  = SW + EW;
  localparam int GRW  = GW + RCW;
  localparam int VW   = 4*MB + 5;
  localparam int VMW  = 4*MB + 4;
  localparam int SVW  = SW + VMW;
  localparam int RRW  = 2*RCW;
  localparam int FW   = 2*MB + 4;
  localparam int TRW  = 2*MB + 2;     // radicand of the output roots
  localparam int RTW  = MB + 1;       // output root width
  localparam int XSW  = (RTW > RB) ? RTW : RB + 1;

  localparam int TW1  = SW + BSW + 2*PW2;
  localparam int TW2  = SW + BSW + QW4;
  localparam int TW4  = BSW + GW + EW;
  localparam int TW5  = SW + BSW + GW + QCW + RCW;
  localparam int TW6  = TW5 + SEW;
  localparam int TW7  = TW5 + 1;
  localparam int TW8  = SW + BSW + GW + QCW + 1 + SVW;
  localparam int TW9  = 3 + TRW;
  localparam int TW10 = 3 + RTW;

  // The whole pipeline advances together whenever the output register can move.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: squares of the components and of the sums.
  // ---------------------------------------------------------------------------
  logic signed [MB-1:0] ax, ay, az, bx, by, bz;
  logic signed [MB:0]   sx, sy, sz;
  logic signed [2*MB-1:0] axx_w, ayy_w, azz_w, bxx_w, byy_w, bzz_w;
  logic signed [2*MB+1:0] sxx_w, syy_w, zz_w;

  logic           s1_vld_r;
  logic [SQW-1:0] axx_r, ayy_r, azz_r, bxx_r, byy_r, bzz_r;
  logic [SSW-1:0] sxx_r, syy_r, zz_r;

  always_comb begin
    ax = $signed(in_tdata[0*MB +: MB]);
    ay = $signed(in_tdata[1*MB +: MB]);
    az = $signed(in_tdata[2*MB +: MB]);
    bx = $signed(in_tdata[3*MB +: MB]);
    by = $signed(in_tdata[4*MB +: MB]);
    bz = $signed(in_tdata[5*MB +: MB]);
    sx = ax + bx;
    sy = ay + by;
    sz = az + bz;
    axx_w = ax * ax;
    ayy_w = ay * ay;
    azz_w = az * az;
    bxx_w = bx * bx;
    byy_w = by * by;
    bzz_w = bz * bz;
    sxx_w = sx * sx;
    syy_w = sy * sy;
    zz_w  = sz * sz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axx_r <= axx_w[SQW-1:0];
      ayy_r <= ayy_w[SQW-1:0];
      azz_r <= azz_w[SQW-1:0];
      bxx_r <= bxx_w[SQW-1:0];
      byy_r <= byy_w[SQW-1:0];
      bzz_r <= bzz_w[SQW-1:0];
      sxx_r <= sxx_w[SSW-1:0];
      syy_r <= syy_w[SSW-1:0];
      zz_r  <= zz_w[SSW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: jet magnitudes, S, base and the transverse difference.
  // ---------------------------------------------------------------------------
  logic [PW2-1:0] at2_w, bt2_w, pa_nxt, pb_nxt, dmag_nxt;
  logic [SW-1:0]  s_nxt;
  logic [BSW-1:0] base_nxt;

  logic           s2_vld_r;
  logic [SW-1:0]  s2_s_r;
  logic [BSW-1:0] s2_base_r;
  logic [PW2-1:0] s2_pa_r, s2_pb_r, s2_dmag_r;

  always_comb begin
    at2_w    = PW2'(axx_r) + PW2'(ayy_r);
    bt2_w    = PW2'(bxx_r) + PW2'(byy_r);
    pa_nxt   = at2_w + PW2'(azz_r);
    pb_nxt   = bt2_w + PW2'(bzz_r);
    dmag_nxt = (bt2_w >= at2_w) ? (bt2_w - at2_w) : (at2_w - bt2_w);
    s_nxt    = SW'(sxx_r) + SW'(syy_r);
    base_nxt = BSW'(pa_nxt) + BSW'(pb_nxt) - BSW'(zz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s_r    <= s_nxt;
      s2_base_r <= base_nxt;
      s2_pa_r   <= pa_nxt;
      s2_pb_r   <= pb_nxt;
      s2_dmag_r <= dmag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // D^2, then Pa*Pb.
  // ---------------------------------------------------------------------------
  logic           m1_vld;
  logic [QW4-1:0] m1_d2;
  logic [TW1-1:0] m1_tag;
  logic [SW-1:0]  m1_s;
  logic [BSW-1:0] m1_base;
  logic [PW2-1:0] m1_pa, m1_pb;

  rmsg_mulp #(.AW(PW2), .BW(PW2), .TW(TW1)) u_mul_d2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s2_vld_r),
    .a_i(s2_dmag_r), .b_i(s2_dmag_r),
    .tag_i({s2_s_r, s2_base_r, s2_pa_r, s2_pb_r}),
    .out_vld(m1_vld), .p_o(m1_d2), .tag_o(m1_tag)
  );
  assign {m1_s, m1_base, m1_pa, m1_pb} = m1_tag;

  logic           m2_vld;
  logic [QW4-1:0] m2_q;
  logic [TW2-1:0] m2_tag;

  rmsg_mulp #(.AW(PW2), .BW(PW2), .TW(TW2)) u_mul_q (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m1_vld),
    .a_i(m1_pa), .b_i(m1_pb),
    .tag_i({m1_s, m1_base, m1_d2}),
    .out_vld(m2_vld), .p_o(m2_q), .tag_o(m2_tag)
  );

  // ---------------------------------------------------------------------------
  // g = floor(sqrt(4*Pa*Pb)) with remainder e.
  // ---------------------------------------------------------------------------
  logic           r1_vld;
  logic [GW-1:0]  r1_g;
  logic [EW-1:0]  r1_e;
  logic [TW2-1:0] r1_tag;
  logic [SW-1:0]  r1_s;
  logic [BSW-1:0] r1_base;
  logic [QW4-1:0] r1_d2;

  rmsg_root #(.RW(QW4 + 2), .TW(TW2)) u_root_q (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m2_vld),
    .rad_i({m2_q, 2'b00}), .tag_i(m2_tag),
    .out_vld(r1_vld), .root_o(r1_g), .rem_o(r1_e), .tag_o(r1_tag)
  );
  assign {r1_s, r1_base, r1_d2} = r1_tag;

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage: D^2 / S.  The quotient is
  // bounded by |bT-aT|^2, so QCW bits always hold it.  A zero S yields garbage
  // here, which the status logic masks.
  // ---------------------------------------------------------------------------
  logic           dv_vld_r [QCW];
  logic [DW-1:0]  drem_r   [QCW];
  logic [QCW-1:0] dquo_r   [QCW];
  logic [SW-1:0]  ds_r     [QCW];
  logic [TW4-1:0] dtag_r   [QCW];

  for (genvar k = 0; k < QCW; k++) begin : g_div
    logic           vld_in;
    logic [DW-1:0]  rem_in;
    logic [QCW-1:0] quo_in;
    logic [SW-1:0]  s_in;
    logic [TW4-1:0] tag_in;
    logic [DW-1:0]  trial;
    logic [DW-1:0]  rem_nxt;
    logic [QCW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign vld_in = r1_vld;
      assign rem_in = DW'(r1_d2);
      assign quo_in = '0;
      assign s_in   = r1_s;
      assign tag_in = {r1_base, r1_g, r1_e};
    end else begin : g_next
      assign vld_in = dv_vld_r[k-1];
      assign rem_in = drem_r[k-1];
      assign quo_in = dquo_r[k-1];
      assign s_in   = ds_r[k-1];
      assign tag_in = dtag_r[k-1];
    end

    always_comb begin
      trial = DW'(s_in) << (QCW - 1 - k);
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        quo_nxt = {quo_in[QCW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_in;
        quo_nxt = {quo_in[QCW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k] <= rem_nxt;
        dquo_r[k] <= quo_nxt;
        ds_r[k]   <= s_in;
        dtag_r[k] <= tag_in;
      end
    end
  end

  logic           dv_vld;
  logic [SW-1:0]  dv_s;
  logic [QCW-1:0] dv_qc;
  logic [RCW-1:0] dv_rc;
  logic [BSW-1:0] dv_base;
  logic [GW-1:0]  dv_g;
  logic [EW-1:0]  dv_e;

  assign dv_vld = dv_vld_r[QCW-1];
  assign dv_s   = ds_r[QCW-1];
  assign dv_qc  = dquo_r[QCW-1];
  assign dv_rc  = drem_r[QCW-1][RCW-1:0];
  assign {dv_base, dv_g, dv_e} = dtag_r[QCW-1];

  // ---------------------------------------------------------------------------
  // V = S*e - 2*g*rc.
  // ---------------------------------------------------------------------------
  logic           m3_vld;
  logic [SEW-1:0] m3_se;
  logic [TW5-1:0] m3_tag;
  logic [SW-1:0]  m3_s;
  logic [BSW-1:0] m3_base;
  logic [GW-1:0]  m3_g;
  logic [QCW-1:0] m3_qc;
  logic [RCW-1:0] m3_rc;

  rmsg_mulp #(.AW(SW), .BW(EW), .TW(TW5)) u_mul_se (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(dv_vld),
    .a_i(dv_s), .b_i(dv_e),
    .tag_i({dv_s, dv_base, dv_g, dv_qc, dv_rc}),
    .out_vld(m3_vld), .p_o(m3_se), .tag_o(m3_tag)
  );
  assign {m3_s, m3_base, m3_g, m3_qc, m3_rc} = m3_tag;

  logic           m4_vld;
  logic [GRW-1:0] m4_grc;
  logic [TW6-1:0] m4_tag;
  logic [TW5-1:0] m4_ctx;
  logic [SEW-1:0] m4_se;

  rmsg_mulp #(.AW(GW), .BW(RCW), .TW(TW6)) u_mul_grc (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m3_vld),
    .a_i(m3_g), .b_i(m3_rc),
    .tag_i({m3_s, m3_base, m3_g, m3_qc, m3_rc, m3_se}),
    .out_vld(m4_vld), .p_o(m4_grc), .tag_o(m4_tag)
  );
  assign {m4_ctx, m4_se} = m4_tag;

  logic [VW-1:0]  v_w;
  logic           v_vld_r;
  logic [TW5-1:0] v_ctx_r;
  logic           v_neg_r;
  logic [VMW-1:0] v_mag_r;

  assign v_w = VW'(m4_se) - (VW'(m4_grc) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else if (en) begin
      v_vld_r <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_ctx_r <= m4_ctx;
      v_neg_r <= v_w[VW-1];
      v_mag_r <= v_w[VW-1] ? '0 : v_w[VMW-1:0];
    end
  end

  logic [SW-1:0]  v_s;
  logic [BSW-1:0] v_base;
  logic [GW-1:0]  v_g;
  logic [QCW-1:0] v_qc;
  logic [RCW-1:0] v_rc;
  assign {v_s, v_base, v_g, v_qc, v_rc} = v_ctx_r;

  // ---------------------------------------------------------------------------
  // S*V and rc^2 for the exact fraction comparison.
  // ---------------------------------------------------------------------------
  logic           m5_vld;
  logic [SVW-1:0] m5_sv;
  logic [TW7-1:0] m5_tag;
  logic [SW-1:0]  m5_s;
  logic [BSW-1:0] m5_base;
  logic [GW-1:0]  m5_g;
  logic [QCW-1:0] m5_qc;
  logic [RCW-1:0] m5_rc;
  logic           m5_vneg;

  rmsg_mulp #(.AW(SW), .BW(VMW), .TW(TW7)) u_mul_sv (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_vld_r),
    .a_i(v_s), .b_i(v_mag_r),
    .tag_i({v_s, v_base, v_g, v_qc, v_rc, v_neg_r}),
    .out_vld(m5_vld), .p_o(m5_sv), .tag_o(m5_tag)
  );
  assign {m5_s, m5_base, m5_g, m5_qc, m5_rc, m5_vneg} = m5_tag;

  logic           m6_vld;
  logic [RRW-1:0] m6_rr;
  logic [TW8-1:0] m6_tag;
  logic [SW-1:0]  m6_s;
  logic [BSW-1:0] m6_base;
  logic [GW-1:0]  m6_g;
  logic [QCW-1:0] m6_qc;
  logic           m6_vneg;
  logic [SVW-1:0] m6_sv;

  rmsg_mulp #(.AW(RCW), .BW(RCW), .TW(TW8)) u_mul_rr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(m5_vld),
    .a_i(m5_rc), .b_i(m5_rc),
    .tag_i({m5_s, m5_base, m5_g, m5_qc, m5_vneg, m5_sv}),
    .out_vld(m6_vld), .p_o(m6_rr), .tag_o(m6_tag)
  );
  assign {m6_s, m6_base, m6_g, m6_qc, m6_vneg, m6_sv} = m6_tag;

  // ---------------------------------------------------------------------------
  // Classify: floor(X), floor(T) and the special cases.
  // ---------------------------------------------------------------------------
  logic              frac_ge, frac_eq;
  logic signed [FW-1:0] f_w;
  logic [TRW-1:0]    t_w;

  logic           c_vld_r;
  logic           c_szero_r, c_fneg_r, c_fzx_r;
  logic [TRW-1:0] c_fmag_r, c_tfl_r;

  always_comb begin
    frac_ge = !m6_vneg && (m6_sv >= SVW'(m6_rr));
    frac_eq = !m6_vneg && (m6_sv == SVW'(m6_rr));
    f_w = FW'($signed(m6_base)) + FW'(m6_g) - FW'(m6_qc) - FW'(!frac_ge);
    t_w = TRW'(m6_base) + TRW'(m6_g);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= m6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_szero_r <= (m6_s == '0);
      c_fneg_r  <= f_w[FW-1];
      c_fzx_r   <= !f_w[FW-1] && (f_w == '0) && frac_eq;
      c_fmag_r  <= f_w[FW-1] ? '0 : f_w[TRW-1:0];
      c_tfl_r   <= t_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Output roots: MR* = isqrt(floor X), gamma*MR* = isqrt(floor T).
  // ---------------------------------------------------------------------------
  logic            r2_vld;
  logic [RTW-1:0]  r2_root;
  logic [TW9-1:0]  r2_tag;
  logic            r2_szero, r2_fneg, r2_fzx;
  logic [TRW-1:0]  r2_tfl;

  rmsg_root #(.RW(TRW), .TW(TW9)) u_root_mr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(c_vld_r),
    .rad_i(c_fmag_r), .tag_i({c_szero_r, c_fneg_r, c_fzx_r, c_tfl_r}),
    .out_vld(r2_vld), .root_o(r2_root), .rem_o(), .tag_o(r2_tag)
  );
  assign {r2_szero, r2_fneg, r2_fzx, r2_tfl} = r2_tag;

  logic            r3_vld;
  logic [RTW-1:0]  r3_root;
  logic [TW10-1:0] r3_tag;
  logic            r3_szero, r3_fneg, r3_fzx;
  logic [RTW-1:0]  r3_mr;

  rmsg_root #(.RW(TRW), .TW(TW10)) u_root_gmr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(r2_vld),
    .rad_i(r2_tfl), .tag_i({r2_szero, r2_fneg, r2_fzx, r2_root}),
    .out_vld(r3_vld), .root_o(r3_root), .rem_o(), .tag_o(r3_tag)
  );
  assign {r3_szero, r3_fneg, r3_fzx, r3_mr} = r3_tag;

  // ---------------------------------------------------------------------------
  // Output register: saturation and status.
  // ---------------------------------------------------------------------------
  logic [XSW-1:0]    mr_ext, gm_ext;
  logic              sat_m, sat_g;
  logic [RB-1:0]     mr_nxt, gm_nxt;
  logic [STAT_W-1:0] st_nxt;

  logic              out_vld_r;
  logic [OW-1:0]     out_data_r;
  logic [STAT_W-1:0] out_user_r;

  always_comb begin
    mr_ext = XSW'(r3_mr);
    gm_ext = XSW'(r3_root);
    sat_m  = mr_ext >= (XSW'(1) << RB);
    sat_g  = gm_ext >= (XSW'(1) << RB);
    if (r3_szero) begin
      mr_nxt = '0;
      gm_nxt = '0;
      st_nxt = ST_ZERO_PT;
    end else if (r3_fneg) begin
      mr_nxt = '0;
      gm_nxt = '0;
      st_nxt = ST_NEG_RAD;
    end else if (r3_fzx) begin
      // MR* is exactly zero, so gamma is infinite.
      mr_nxt = '0;
      gm_nxt = '1;
      st_nxt = ST_GAMMA_SAT;
    end else begin
      mr_nxt = sat_m ? '1 : RB'(mr_ext);
      gm_nxt = sat_g ? '1 : RB'(gm_ext);
      st_nxt = (sat_m || sat_g) ? ST_GAMMA_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= r3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OW'({gm_nxt, mr_nxt});
      out_user_r <= st_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("output word valid right after reset");

  // Failed cases carry zero results.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO_PT || out_tuser == ST_NEG_RAD)
      |-> out_tdata[2*RB-1:0] == '0)
    else $error("nonzero result on a failed status");

  // MR* never exceeds gamma*MR* on a clean result.
  a_mr_le_gmr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |-> out_tdata[RB-1:0] <= out_tdata[2*RB-1:RB])
    else $error("mr_star above gamma_mr_star");

  // A gamma-undefined result with zero MR* reports a saturated gamma*MR*.
  a_gamma_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_GAMMA_SAT && out_tdata[RB-1:0] == '0
      |-> out_tdata[2*RB-1:RB] == '1)
    else $error("infinite gamma without saturated gamma_mr_star");

endmodule

/* test/razor_mr_star_gamma_core_test.sv */
`timescale 1ns / 1ps

module razor_mr_star_gamma_core_test;
  import rmsg_pkg::*;

  localparam int MB = MOMENTUM_BITS_DEF;
  localparam int RB = RESULT_BITS_DEF;
  localparam int IN_W = ((6*MB+7)/8)*8;
  localparam int OUT_W = ((2*RB+7)/8)*8;
  localparam logic [RB-1:0] TOP = '1;
  localparam int N_RANDOM = 1540;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 400000;

  // Wide unsigned arithmetic for exact comparisons of squares.
  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [RB-1:0] mr;
    logic [RB-1:0] gmr;
    logic [STAT_W-1:0] st;
  } razor_result_t;

  typedef struct {
    logic signed [MB-1:0] comp [6];
    bit known;
    razor_result_t res;
  } jet_pair_row_t;

  logic clk;
  logic rst_n;
  logic [IN_W-1:0] in_tdata;
  logic in_tvalid;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic out_tvalid;
  logic out_tready;

  // A row whose result is typed in travels beside its data word.
  logic row_known;
  razor_result_t row_res;

  razor_result_t pending_results[$];
  int errors;
  int words_sent;
  int words_checked;
  int status_seen [4];
  longint cycles;
  bit quiet;
  bit hold_request;

  razor_mr_star_gamma_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sign of L - 2*s*sqrt(q) with L = s*(m^2 - psum + z2) + d2. A result <= 0 means
  // that m is not above the root being searched.
  function automatic int root_compare(longint unsigned s, longint unsigned m, wide_t d2,
                                      longint unsigned psum, longint unsigned z2,
                                      wide_t q);
    wide_t pos, neg, l, rhs;
    pos = wide_t'(s) * wide_t'(m * m + z2) + d2;
    neg = wide_t'(s) * wide_t'(psum);
    if (pos < neg) return -1;
    l = pos - neg;
    rhs = wide_t'(4) * wide_t'(s) * wide_t'(s) * q;
    if (l * l < rhs) return -1;
    if (l * l > rhs) return 1;
    return 0;
  endfunction

  // Bit-by-bit floor of the root; flags a value that does not fit RB bits.
  function automatic logic [RB-1:0] root_floor(longint unsigned s, wide_t d2,
                                               longint unsigned psum,
                                               longint unsigned z2, wide_t q,
                                               output bit sat);
    longint unsigned m, c;
    m = 0;
    for (int b = RB - 1; b >= 0; b--) begin
      c = m | (64'd1 << b);
      if (root_compare(s, c, d2, psum, z2, q) <= 0) m = c;
    end
    sat = root_compare(s, 64'd1 << RB, d2, psum, z2, q) <= 0;
    return m[RB-1:0];
  endfunction

  function automatic razor_result_t razor_predict(logic [IN_W-1:0] d);
    longint signed ax, ay, az, bx, by, bz, sx, sy, zs;
    longint unsigned at2, bt2, pa, pb, s, z2, dmag, psum;
    wide_t d2, q;
    int r0;
    bit sat_m, sat_g;
    razor_result_t r;
    ax = $signed(d[0*MB +: MB]);
    ay = $signed(d[1*MB +: MB]);
    az = $signed(d[2*MB +: MB]);
    bx = $signed(d[3*MB +: MB]);
    by = $signed(d[4*MB +: MB]);
    bz = $signed(d[5*MB +: MB]);
    sx = ax + bx;
    sy = ay + by;
    zs = az + bz;
    at2 = ax * ax + ay * ay;
    bt2 = bx * bx + by * by;
    pa = at2 + az * az;
    pb = bt2 + bz * bz;
    s = sx * sx + sy * sy;
    z2 = zs * zs;
    dmag = (bt2 >= at2) ? bt2 - at2 : at2 - bt2;
    d2 = wide_t'(dmag) * wide_t'(dmag);
    q = wide_t'(pa) * wide_t'(pb);
    psum = pa + pb;
    r = '{mr: '0, gmr: '0, st: ST_OK};
    if (s == 0) begin
      r.st = ST_ZERO_PT;
      return r;
    end
    r0 = root_compare(s, 64'd0, d2, psum, z2, q);
    if (r0 > 0) begin
      r.st = ST_NEG_RAD;
      return r;
    end
    if (r0 == 0) begin
      r.gmr = TOP;
      r.st = ST_GAMMA_SAT;
      return r;
    end
    r.mr = root_floor(s, d2, psum, z2, q, sat_m);
    r.gmr = root_floor(64'd1, '0, psum, z2, q, sat_g);
    if (sat_m) begin
      r.mr = TOP;
      r.st = ST_GAMMA_SAT;
    end
    if (sat_g) begin
      r.gmr = TOP;
      r.st = ST_GAMMA_SAT;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH word %0d %s: got %0d, expected %0d", words_checked, what, got, want);
  endtask

  // Every accepted word gets its expected result queued at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (row_known) pending_results.push_back(row_res);
      else pending_results.push_back(razor_predict(in_tdata));
    end
  end

  always @(posedge clk) begin
    razor_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result words against words sent", words_checked + 1, words_sent);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[RB-1:0] !== want.mr)
          report_mismatch("mr_star", out_tdata[RB-1:0], want.mr);
        if (out_tdata[2*RB-1:RB] !== want.gmr)
          report_mismatch("gamma_mr_star", out_tdata[2*RB-1:RB], want.gmr);
        if (out_tuser !== want.st)
          report_mismatch("status", out_tuser, want.st);
        if (out_tuser !== 'x) status_seen[out_tuser]++;
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("razor_mr_star_gamma_core_test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off so the pipeline fills and
  // backs up into in_tready, and no stalls in the closing part.
  initial begin
    bit held;
    held = 0;
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_pair(logic signed [MB-1:0] comp [6], bit known, razor_result_t res);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 6; i++) w[i*MB +: MB] = comp[i];
    in_tdata <= w;
    row_known <= known;
    row_res <= res;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (words_sent == 500) hold_request = 1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic logic signed [MB-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(MB-1){1'b0}}};
      1: return {1'b0, {(MB-1){1'b1}}};
      2: return '1;
      3: return MB'(1);
      default: return MB'(0);
    endcase
  endfunction

  jet_pair_row_t directed [$];

  task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
                         bit known = 0, razor_result_t res = '0);
    jet_pair_row_t row;
    row.comp[0] = MB'(ax); row.comp[1] = MB'(ay); row.comp[2] = MB'(az);
    row.comp[3] = MB'(bx); row.comp[4] = MB'(by); row.comp[5] = MB'(bz);
    row.known = known;
    row.res = res;
    directed.push_back(row);
  endtask

  initial begin
    logic signed [MB-1:0] comp [6];
    int mode, scale;
    razor_result_t none;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    cycles = 0;
    quiet = 0;
    hold_request = 0;
    none = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    row_known = 1'b0;
    row_res = '0;

    // Zero transverse sums, including opposite jets with longitudinal momentum, then one large nonzero sum.
    add_row(0, 0, 0, 0, 0, 0, 1, '{mr: 0, gmr: 0, st: ST_ZERO_PT});
    add_row(1, 0, 0, -1, 0, 0, 1, '{mr: 0, gmr: 0, st: ST_ZERO_PT});
    add_row(32767, 0, 0, -32767, 0, 77, 1, '{mr: 0, gmr: 0, st: ST_ZERO_PT});
    add_row(-32768, 32767, -32768, -32768, 32767, 32767, 0);
    // A single transverse jet leaves a radicand of exactly zero: gamma is infinite.
    add_row(1, 0, 0, 0, 0, 0, 1, '{mr: 0, gmr: TOP, st: ST_GAMMA_SAT});
    add_row(0, 1, 0, 0, 0, 0, 1, '{mr: 0, gmr: TOP, st: ST_GAMMA_SAT});
    add_row(0, -32768, 0, 0, 0, 0, 1, '{mr: 0, gmr: TOP, st: ST_GAMMA_SAT});
    // Extremes of every field, then assorted small and mid-range pairs.
    add_row(-32768, -32768, -32768, -32768, -32768, -32768);
    add_row(32767, 32767, 32767, 32767, 32767, 32767);
    add_row(32767, 32767, 32767, -32768, -32768, -32768);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767);
    add_row(-1, -1, -1, -1, -1, -1);
    add_row(2, 0, 0, -1, 0, 0);
    add_row(0, 0, 100, 3, 0, 0);
    add_row(40, 30, -500, 40, 30, 500);
    add_row(1000, -2000, 3000, -999, 2001, -3000);
    add_row(32767, 0, -32768, 0, 32767, 32767);
    add_row(-32768, 0, 0, 0, -32768, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_pair(directed[i].comp, directed[i].known, directed[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 200) quiet = 1;
      mode = $urandom_range(0, 11);
      for (int i = 0; i < 6; i++) begin
        case (mode)
          0, 1, 2, 3: comp[i] = MB'($urandom);
          4: comp[i] = MB'($signed($urandom_range(0, 128)) - 64);
          5: comp[i] = extreme_value();
          default: comp[i] = MB'($urandom);
        endcase
      end
      case (mode)
        6: begin
          // Back-to-back transverse momenta.
          comp[3] = -comp[0];
          comp[4] = -comp[1];
        end
        7: begin
          comp[3] = '0; comp[4] = '0; comp[5] = '0;
        end
        8: begin
          comp[3] = '0; comp[4] = '0;
        end
        9: begin
          // Jets along one transverse direction, second jet scaled down by a factor from 1 to 64.
          scale = $urandom_range(1, 64);
          comp[3] = MB'(comp[0] / scale);
          comp[4] = MB'(comp[1] / scale);
        end
        10: begin
          comp[3] = MB'(comp[0] + $signed($urandom_range(0, 6)) - 3);
          comp[4] = comp[1];
          comp[5] = -comp[2];
        end
        default: ;
      endcase
      send_pair(comp, 0, none);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d jet pairs sent and %0d results checked, incl. a %0d-cycle output stall",
             words_sent, words_checked, HOLD_CYCLES);
    $display("status counts: ok %0d, zero pT sum %0d, negative radicand %0d, saturated %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("razor_mr_star_gamma_core_test passed");
    end else begin
      $display("razor_mr_star_gamma_core_test failed");
    end
    $finish;
  end

endmodule
